// ----- rtl/core/skh_pkg.sv -----
// Package for the streaming key hash: stage interface type, tail codes and
// the round, tail and avalanche functions. No dependencies.
package skh_pkg;

    localparam int unsigned HashWidth = 32;

    typedef logic [HashWidth-1:0] hash_t;

    // Byte count of a word that ends the key short of four bytes
    typedef logic [1:0] tail_code_t;
    localparam tail_code_t TAIL_NONE  = 2'd0;
    localparam tail_code_t TAIL_ONE   = 2'd1;
    localparam tail_code_t TAIL_TWO   = 2'd2;
    localparam tail_code_t TAIL_THREE = 2'd3;

    // Finished-key hash handed from the accumulate stage to the final stage
    typedef struct packed {
        logic  valid;
        hash_t hash;
    } skh_mid_t;

    function automatic hash_t mix_word(input hash_t h_in, input hash_t w);
        hash_t h;
        hash_t t;
        h = h_in + {16'd0, w[15:0]};
        t = {5'd0, w[31:16], 11'd0} ^ h;
        h = {h[15:0], 16'd0} ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic hash_t apply_tail(input hash_t h_in, input hash_t w,
                                         input tail_code_t n);
        hash_t h;
        hash_t ext;
        h   = h_in;
        ext = {{24{w[23]}}, w[23:16]};
        unique case (n)
            TAIL_THREE:
            begin
                h = h + {16'd0, w[15:0]};
                h = h ^ (h << 16);
                h = h ^ (ext << 18);
                h = h + (h >> 11);
            end
            TAIL_TWO:
            begin
                h = h + {16'd0, w[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            TAIL_ONE:
            begin
                h = h + {24'd0, w[7:0]};
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            TAIL_NONE:
            begin
                h = h_in;
            end
            default:
            begin
                h = h_in;
            end
        endcase
        return h;
    endfunction

    function automatic hash_t avalanche(input hash_t h_in);
        hash_t h;
        h = h_in;
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

endpackage

// ----- rtl/core/skh_accum.sv -----
// Accumulate stage: input register, running hash, word round and tail.
// Depends on skh_pkg.
module skh_accum (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               key_valid,
    output logic               key_ready,
    input  logic [31:0]        data_word,
    input  logic [2:0]         byte_count,
    input  logic               last_word,
    output skh_pkg::skh_mid_t  mid,
    input  logic               mid_ready
);

    logic                 s0_valid_reg, s0_valid_next;
    logic [31:0]          s0_data_reg;
    logic                 s0_full_reg;
    skh_pkg::tail_code_t  s0_tail_reg;
    logic                 s0_last_reg;
    skh_pkg::hash_t       run_hash_reg, run_hash_next;
    logic                 mid_valid_reg, mid_valid_next;
    skh_pkg::hash_t       mid_hash_reg;

    skh_pkg::hash_t       h_full;
    skh_pkg::hash_t       h_tail;
    logic                 emit;
    logic                 s1_free;
    logic                 s0_fire;
    logic                 load;

    always_comb
    begin
        h_full  = skh_pkg::mix_word(run_hash_reg, s0_data_reg);
        h_tail  = skh_pkg::apply_tail(run_hash_reg, s0_data_reg, s0_tail_reg);
        emit    = !s0_full_reg || s0_last_reg;
        s1_free = !mid_valid_reg || mid_ready;
        s0_fire = s0_valid_reg && (!emit || s1_free);
        key_ready = !s0_valid_reg || s0_fire;
        load    = key_valid && key_ready;
    end

    always_comb
    begin
        s0_valid_next = load ? 1'b1 : (s0_fire ? 1'b0 : s0_valid_reg);
        run_hash_next = run_hash_reg;
        if (s0_fire)
        begin
            run_hash_next = emit ? '0 : h_full;
        end
        if (s0_fire && emit)
        begin
            mid_valid_next = 1'b1;
        end
        else if (mid_ready)
        begin
            mid_valid_next = 1'b0;
        end
        else
        begin
            mid_valid_next = mid_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            run_hash_reg  <= '0;
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= s0_valid_next;
            run_hash_reg  <= run_hash_next;
            mid_valid_reg <= mid_valid_next;
        end
    end

    // Payload registers: capture on accept, oversized counts act as four
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s0_data_reg <= data_word;
            s0_full_reg <= byte_count[2];
            s0_tail_reg <= byte_count[1:0];
            s0_last_reg <= last_word;
        end
        if (s0_fire && emit)
        begin
            mid_hash_reg <= s0_full_reg ? h_full : h_tail;
        end
    end

    assign mid.valid = mid_valid_reg;
    assign mid.hash  = mid_hash_reg;

endmodule

// ----- rtl/core/skh_final.sv -----
// Final stage: avalanche of the finished key hash into the result register.
// Depends on skh_pkg.
module skh_final (
    input  logic               clk,
    input  logic               rst_n,
    input  skh_pkg::skh_mid_t  mid,
    output logic               mid_ready,
    output logic               hash_valid,
    input  logic               hash_ready,
    output logic [31:0]        hash_value
);

    logic            hash_valid_reg, hash_valid_next;
    skh_pkg::hash_t  hash_value_reg;
    logic            out_free;
    logic            take;

    always_comb
    begin
        out_free  = !hash_valid_reg || hash_ready;
        mid_ready = out_free;
        take      = mid.valid && out_free;
        if (take)
        begin
            hash_valid_next = 1'b1;
        end
        else if (hash_ready)
        begin
            hash_valid_next = 1'b0;
        end
        else
        begin
            hash_valid_next = hash_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_valid_reg <= 1'b0;
        end
        else
        begin
            hash_valid_reg <= hash_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hash_value_reg <= skh_pkg::avalanche(mid.hash);
        end
    end

    assign hash_valid = hash_valid_reg;
    assign hash_value = hash_value_reg;

endmodule

// ----- rtl/core/superfast_key_hash.sv -----
// Top level of the streaming key hash: accumulate stage and final stage.
// Depends on skh_pkg, skh_accum and skh_final.
//
// Usage: a key enters on the key channel (key_valid/key_ready) four bytes a
// word, little-endian, first byte in data_word[7:0]. byte_count gives the
// valid bytes (counts above four act as four); a word with fewer than four
// bytes, or any word with last_word set, ends the key. The finished hash
// leaves on the hash channel (hash_valid/hash_ready), one word per key; the
// hash of an empty key is zero. Words that do not end the key give no
// result. The running hash starts at zero after reset and after every key.
//
// Throughput is one word per cycle while the finished-hash register can take
// a key-ending word: the input register feeds the round or tail logic, which
// updates the running hash in the same cycle, so the next word of the key
// follows directly. Toward hash_valid, a word passes the input register,
// the finished-hash register, then the avalanche into the result register.
//
// Reset empties every stage and clears the running hash. When the receiver
// stalls, the result register holds, the finished-hash register fills next,
// and words that do not end a key keep flowing until a key-ending word has
// nowhere to go; key_ready then drops until hash_ready frees a stage.
module superfast_key_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_valid,
    output logic        key_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last_word,
    output logic        hash_valid,
    input  logic        hash_ready,
    output logic [31:0] hash_value
);

    skh_pkg::skh_mid_t mid;
    logic              mid_ready;

    skh_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_valid  (key_valid),
        .key_ready  (key_ready),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last_word  (last_word),
        .mid        (mid),
        .mid_ready  (mid_ready)
    );

    skh_final u_final (
        .clk        (clk),
        .rst_n      (rst_n),
        .mid        (mid),
        .mid_ready  (mid_ready),
        .hash_valid (hash_valid),
        .hash_ready (hash_ready),
        .hash_value (hash_value)
    );

    // A finished hash waiting between the stages holds until taken
    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mid.valid && !mid_ready |=> mid.valid && $stable(mid.hash))
        else $error("finished hash changed while stalled");

    // With the middle stage empty, the input side can never be blocked
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !mid.valid |-> key_ready)
        else $error("key_ready low with an empty middle stage");

    // A result appears only after a finished hash was waiting to move
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hash_valid) |-> $past(mid.valid && mid_ready))
        else $error("result appeared without a finished hash");

endmodule
